@@ sv/tlik_pkg.sv @@
// Shared types and constants for the two-link inverse kinematics pipeline.
// No dependencies; imported by tlik_div, tlik_cordic, tlik_acos and the top level.
package tlik_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int LEN_WIDTH    = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_BITS     = 30;
    localparam int ZW           = 33;   // unsigned Q30 angle, up to pi plus margin

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
        30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
        30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
        30'd31,        30'd15,        30'd8,         30'd4,         30'd2
    };

    // 1 - c^2 in Q60 and its square root
    localparam int QSQ_W = 61;
    localparam int S_LAT = (QSQ_W + 1) / 2;

    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    localparam int DIV_LAT    = DIV_BITS + 1;
    localparam int ACOS_LAT   = DIV_LAT + 1 + S_LAT + CORDIC_LAT;

    // radians Q30 -> hundredths of a degree, scale 2^-40
    localparam logic [22:0] DEG_SCALE = 23'd5867088;
    localparam logic [15:0] ALPHA_MAX = 16'd36000;
    localparam logic [14:0] BETA_MAX  = 15'd18000;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_LEN   = 3'd1,
        ST_ZERO_COORD = 3'd2,
        ST_TOO_FAR    = 3'd3,
        ST_TOO_CLOSE  = 3'd4
    } status_t;

    typedef enum logic {
        REG_UPPER_ARM = 1'b0,
        REG_FORE_ARM  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
    } target_t;

    typedef struct packed {
        logic [15:0] shoulder_angle;
        logic [14:0] elbow_angle;
        status_t     status;
    } result_t;

endpackage

@@ sv/two_link_inverse_kinematics.sv @@
// Top level of the two-link planar arm inverse kinematics pipeline.
// Uses tlik_pkg, tlik_isqrt, tlik_delay, tlik_acos and tlik_cordic.
//
// Usage:
//   Write the upper and fore arm lengths (unsigned Q8.8) through cfg_we,
//   cfg_index and cfg_data while no target is in flight. Targets (signed
//   Q8.8 x, y) arrive on the target channel, results (shoulder and elbow
//   angle in 0.01 degree, status) leave on the result channel; both are
//   valid/ready, a transfer happens when valid and ready are high together.
//   Each arccosine runs a divider, a square root and a CORDIC chain. A new
//   target is taken every cycle unless a result is waiting for result_ready.
//   Reset clears both arm lengths to zero and empties the pipeline.
//   While a result waits for result_ready the whole pipeline holds and
//   target_ready is low; nothing is lost or repeated.
//   A nonzero status forces both angles to zero.
module two_link_inverse_kinematics (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  tlik_pkg::reg_index_t                cfg_index,
    input  logic [tlik_pkg::LEN_WIDTH-1:0]      cfg_data,
    input  logic                                target_valid,
    output logic                                target_ready,
    input  tlik_pkg::target_t                   target,
    output logic                                result_valid,
    input  logic                                result_ready,
    output tlik_pkg::result_t                   result
);
    import tlik_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int LW    = LEN_WIDTH;
    localparam int P2W   = 2 * CW;
    localparam int PIN_W = P2W + 16;
    localparam int PW    = (PIN_W + 1) / 2;
    localparam int AW    = ((P2W + 1 > 34) ? P2W + 1 : 34) + 1;
    localparam int CMPW  = (P2W > 34) ? P2W : 34;
    localparam int DBW   = LW + PW;
    localparam int BW    = 2 * CW + 3 + 2 * AW + 33 + LW;
    localparam int HW    = 58;
    localparam int LAT   = 4 + PW + 1 + ACOS_LAT + 3;
    localparam logic [HW-1:0] HALF_LSB = HW'(1) << 39;

    // control state
    logic [LW-1:0]  upper_reg, upper_next;
    logic [LW-1:0]  fore_reg, fore_next;
    logic [LAT-1:0] vld_reg, vld_next;
    logic           adv;

    assign adv          = !(vld_reg[LAT-1] && !result_ready);
    assign target_ready = adv;
    assign result_valid = vld_reg[LAT-1];

    always_comb
    begin
        upper_next = upper_reg;
        fore_next  = fore_reg;
        if (cfg_we && cfg_index == REG_UPPER_ARM)
        begin
            upper_next = cfg_data;
        end
        if (cfg_we && cfg_index == REG_FORE_ARM)
        begin
            fore_next = cfg_data;
        end
        vld_next = adv ? {vld_reg[LAT-2:0], target_valid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            fore_reg  <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            upper_reg <= upper_next;
            fore_reg  <= fore_next;
            vld_reg   <= vld_next;
        end
    end

    // stage 1: capture
    logic signed [CW-1:0] tx1_reg, ty1_reg;
    logic [LW-1:0]        l11_reg, l21_reg;

    // stage 2: squares and products
    logic signed [P2W-1:0] sqx2, sqy2;
    logic [31:0]           l1sq2, l2sq2, l1l22;
    logic [CW-1:0]         ay2;
    logic [P2W-1:0]        sqx2_reg, sqy2_reg;
    logic [31:0]           l1sq2_reg, l2sq2_reg, l1l22_reg;
    logic signed [CW-1:0]  x2_reg;
    logic [CW-1:0]         ay2_reg;
    logic                  zc2_reg, zl2_reg;
    logic [LW-1:0]         l12_reg;

    assign sqx2  = tx1_reg * tx1_reg;
    assign sqy2  = ty1_reg * ty1_reg;
    assign l1sq2 = l11_reg * l11_reg;
    assign l2sq2 = l21_reg * l21_reg;
    assign l1l22 = l11_reg * l21_reg;
    assign ay2   = ty1_reg[CW-1] ? CW'(-ty1_reg) : CW'(ty1_reg);

    // stage 3: sums
    logic [P2W-1:0]       p23_reg;
    logic [33:0]          sumsq3_reg, difsq3_reg;
    logic [32:0]          sl3_reg;
    logic signed [32:0]   dl3_reg;
    logic [32:0]          dg3_reg;
    logic signed [CW-1:0] x3_reg;
    logic [CW-1:0]        ay3_reg;
    logic                 zc3_reg, zl3_reg;
    logic [LW-1:0]        l13_reg;

    // stage 4: status and cosine-law numerators
    status_t              st4;
    logic [P2W-1:0]       p24_reg;
    logic [2:0]           st4_reg;
    logic signed [AW-1:0] a4_reg, g4_reg;
    logic [32:0]          dg4_reg;
    logic signed [CW-1:0] x4_reg;
    logic [CW-1:0]        ay4_reg;
    logic [LW-1:0]        l14_reg;

    always_comb
    begin
        if (zl3_reg)
        begin
            st4 = ST_ZERO_LEN;
        end
        else if (zc3_reg)
        begin
            st4 = ST_ZERO_COORD;
        end
        else if (CMPW'(p23_reg) > CMPW'(sumsq3_reg))
        begin
            st4 = ST_TOO_FAR;
        end
        else if (CMPW'(p23_reg) < CMPW'(difsq3_reg))
        begin
            st4 = ST_TOO_CLOSE;
        end
        else
        begin
            st4 = ST_OK;
        end
    end

    // P = sqrt(p2 * 2^16) with the rest of the item riding alongside
    logic [PW-1:0]        big_p;
    logic [BW-1:0]        bundle_d;
    logic signed [CW-1:0] x_d;
    logic [CW-1:0]        ay_d;
    logic [2:0]           st_d;
    logic signed [AW-1:0] a_d, g_d;
    logic [32:0]          dg_d;
    logic [LW-1:0]        l1_d;

    tlik_isqrt #(.IN_W(PIN_W)) u_psqrt (
        .clk (clk), .en (adv), .value ({p24_reg, 16'h0000}), .root (big_p)
    );

    tlik_delay #(.W(BW), .DEPTH(PW)) u_side_dly (
        .clk (clk),
        .en  (adv),
        .d   ({x4_reg, ay4_reg, st4_reg, a4_reg, g4_reg, dg4_reg, l14_reg}),
        .q   (bundle_d)
    );

    assign {x_d, ay_d, st_d, a_d, g_d, dg_d, l1_d} = bundle_d;

    // stage 5: divider operands
    logic [DBW-1:0]       db5;
    logic [AW-1:0]        abs_a, abs_g;
    logic [AW+6:0]        nb5_reg;
    logic [DBW-1:0]       db5_reg;
    logic                 negb5_reg, negg5_reg;
    logic [AW-1:0]        ng5_reg;
    logic [32:0]          dg5_reg;
    logic signed [CW-1:0] x5_reg;
    logic [CW-1:0]        ay5_reg;
    logic [2:0]           st5_reg;

    assign db5   = DBW'(l1_d) * DBW'(big_p);
    assign abs_a = a_d[AW-1] ? AW'(-a_d) : AW'(a_d);
    assign abs_g = g_d[AW-1] ? AW'(-g_d) : AW'(g_d);

    // three angles in parallel
    logic [ZW-1:0]        za, za_d, zb, zg;
    logic [2:0]           st_a;
    logic signed [CW:0]   zx;
    logic signed [CW:0]   zy;

    assign zx = (CW+1)'(x5_reg);
    assign zy = $signed({1'b0, ay5_reg});

    tlik_cordic #(.IN_W(CW+1)) u_za (
        .clk (clk), .en (adv), .x (zx), .y (zy), .angle (za)
    );

    tlik_delay #(.W(ZW), .DEPTH(ACOS_LAT - CORDIC_LAT)) u_za_dly (
        .clk (clk), .en (adv), .d (za), .q (za_d)
    );

    tlik_acos #(.N_W(AW+7), .D_W(DBW)) u_zb (
        .clk (clk), .en (adv), .neg (negb5_reg), .n (nb5_reg), .d (db5_reg), .angle (zb)
    );

    tlik_acos #(.N_W(AW), .D_W(33)) u_zg (
        .clk (clk), .en (adv), .neg (negg5_reg), .n (ng5_reg), .d (dg5_reg), .angle (zg)
    );

    tlik_delay #(.W(3), .DEPTH(ACOS_LAT)) u_st_dly (
        .clk (clk), .en (adv), .d (st5_reg), .q (st_a)
    );

    // stages 6 to 8: sum, scale to hundredths, round and clamp
    logic [ZW:0]    zs6_reg;
    logic [ZW-1:0]  zg6_reg;
    logic [2:0]     st6_reg;
    logic [HW-1:0]  ha7, hb7;
    logic [HW-1:0]  ha7_reg, hb7_reg;
    logic [2:0]     st7_reg;
    logic [HW-1:0]  ra, rb;
    logic [HW-41:0] alpha_raw, beta_raw;
    result_t        result_next;
    result_t        result_reg;

    assign ha7 = HW'(zs6_reg) * HW'(DEG_SCALE);
    assign hb7 = HW'(zg6_reg) * HW'(DEG_SCALE);
    assign ra  = ha7_reg + HALF_LSB;
    assign rb  = hb7_reg + HALF_LSB;
    assign alpha_raw = ra[HW-1:40];
    assign beta_raw  = rb[HW-1:40];

    always_comb
    begin
        result_next.status         = status_t'(st7_reg);
        result_next.shoulder_angle = (alpha_raw > (HW-40)'(ALPHA_MAX)) ? ALPHA_MAX
                                                                       : alpha_raw[15:0];
        result_next.elbow_angle    = (beta_raw > (HW-40)'(BETA_MAX)) ? BETA_MAX
                                                                     : beta_raw[14:0];
        if (status_t'(st7_reg) != ST_OK)
        begin
            result_next.shoulder_angle = '0;
            result_next.elbow_angle    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx1_reg    <= target.target_x;
            ty1_reg    <= target.target_y;
            l11_reg    <= upper_reg;
            l21_reg    <= fore_reg;

            sqx2_reg   <= P2W'(sqx2);
            sqy2_reg   <= P2W'(sqy2);
            l1sq2_reg  <= l1sq2;
            l2sq2_reg  <= l2sq2;
            l1l22_reg  <= l1l22;
            x2_reg     <= tx1_reg;
            ay2_reg    <= ay2;
            zc2_reg    <= (tx1_reg == '0) || (ty1_reg == '0);
            zl2_reg    <= (l11_reg == '0) || (l21_reg == '0);
            l12_reg    <= l11_reg;

            p23_reg    <= sqx2_reg + sqy2_reg;
            sumsq3_reg <= 34'(l1sq2_reg) + 34'(l2sq2_reg) + {1'b0, l1l22_reg, 1'b0};
            difsq3_reg <= 34'(l1sq2_reg) + 34'(l2sq2_reg) - {1'b0, l1l22_reg, 1'b0};
            sl3_reg    <= 33'(l1sq2_reg) + 33'(l2sq2_reg);
            dl3_reg    <= $signed(33'(l1sq2_reg) - 33'(l2sq2_reg));
            dg3_reg    <= {l1l22_reg, 1'b0};
            x3_reg     <= x2_reg;
            ay3_reg    <= ay2_reg;
            zc3_reg    <= zc2_reg;
            zl3_reg    <= zl2_reg;
            l13_reg    <= l12_reg;

            p24_reg    <= p23_reg;
            st4_reg    <= st4;
            a4_reg     <= $signed(AW'(p23_reg) + AW'(dl3_reg));
            g4_reg     <= $signed(AW'(p23_reg) - AW'(sl3_reg));
            dg4_reg    <= dg3_reg;
            x4_reg     <= x3_reg;
            ay4_reg    <= ay3_reg;
            l14_reg    <= l13_reg;

            nb5_reg    <= {abs_a, 7'b0};
            db5_reg    <= db5;
            negb5_reg  <= a_d[AW-1];
            ng5_reg    <= abs_g;
            negg5_reg  <= g_d[AW-1];
            dg5_reg    <= dg_d;
            x5_reg     <= x_d;
            ay5_reg    <= ay_d;
            st5_reg    <= st_d;

            zs6_reg    <= (ZW+1)'(za_d) + (ZW+1)'(zb);
            zg6_reg    <= zg;
            st6_reg    <= st_a;

            ha7_reg    <= ha7;
            hb7_reg    <= hb7;
            st7_reg    <= st6_reg;

            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    // failed items carry no angles
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.shoulder_angle == '0 && result.elbow_angle == '0)
        else $error("angles nonzero on failed item");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.shoulder_angle <= ALPHA_MAX &&
                         result.elbow_angle <= BETA_MAX)
        else $error("angle out of range");

    // a stall freezes every valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !target_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        target_valid && target_ready |=> vld_reg[0])
        else $error("accepted transfer not in first stage");
endmodule

@@ sv/tlik_delay.sv @@
// Enabled shift line that keeps side data aligned with pipelined units.
// Depends on nothing.
module tlik_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] d_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    assign q = d_reg[DEPTH-1];
endmodule

@@ sv/tlik_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on nothing.
module tlik_isqrt #(
    parameter int IN_W = 61
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [IN_W-1:0]           value,
    output logic [(IN_W+1)/2-1:0]     root
);
    localparam int N  = (IN_W + 1) / 2;
    localparam int W2 = 2 * N + 1;

    logic [W2-1:0] v_reg  [N];
    logic [W2-1:0] r_reg  [N];
    logic [W2-1:0] v_next [N];
    logic [W2-1:0] r_next [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic [W2-1:0] BIT = W2'(1) << (2 * (N - 1 - i));
        logic [W2-1:0] v_in;
        logic [W2-1:0] r_in;
        logic [W2-1:0] cand;
        if (i == 0)
        begin : g_first
            assign v_in = W2'(value);
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[i-1];
            assign r_in = r_reg[i-1];
        end
        assign cand      = r_in + BIT;
        assign v_next[i] = (v_in >= cand) ? v_in - cand : v_in;
        assign r_next[i] = (v_in >= cand) ? (r_in >> 1) + BIT : (r_in >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = N'(r_reg[N-1]);
endmodule

@@ sv/tlik_div.sv @@
// Pipelined restoring divider giving min(n/d, 1) as a Q30 fraction.
// Uses tlik_pkg.
module tlik_div #(
    parameter int N_W = 41,
    parameter int D_W = 40
) (
    input  logic           clk,
    input  logic           en,
    input  logic [N_W-1:0] n,
    input  logic [D_W-1:0] d,
    output logic [30:0]    q
);
    import tlik_pkg::*;

    localparam int MW = (N_W > D_W) ? N_W : D_W;

    logic [D_W-1:0]      r_reg    [DIV_BITS+1];
    logic [D_W-1:0]      d_reg    [DIV_BITS+1];
    logic [DIV_BITS-1:0] q_reg    [DIV_BITS+1];
    logic                big_reg  [DIV_BITS+1];
    logic [D_W-1:0]      r_next   [DIV_BITS+1];
    logic [D_W-1:0]      d_next   [DIV_BITS+1];
    logic [DIV_BITS-1:0] q_next   [DIV_BITS+1];
    logic                big_next [DIV_BITS+1];

    // ratio of one or more saturates; otherwise n < d so the remainder fits D_W
    assign big_next[0] = MW'(n) >= MW'(d);
    assign r_next[0]   = big_next[0] ? '0 : D_W'(n);
    assign d_next[0]   = d;
    assign q_next[0]   = '0;

    for (genvar i = 0; i < DIV_BITS; i++)
    begin : g_step
        logic [D_W:0] r2;
        logic         ge;
        assign r2            = {r_reg[i], 1'b0};
        assign ge            = r2 >= {1'b0, d_reg[i]};
        assign r_next[i+1]   = ge ? D_W'(r2 - {1'b0, d_reg[i]}) : D_W'(r2);
        assign q_next[i+1]   = {q_reg[i][DIV_BITS-2:0], ge};
        assign d_next[i+1]   = d_reg[i];
        assign big_next[i+1] = big_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_BITS; k++)
            begin
                r_reg[k]   <= r_next[k];
                d_reg[k]   <= d_next[k];
                q_reg[k]   <= q_next[k];
                big_reg[k] <= big_next[k];
            end
        end
    end

    assign q = big_reg[DIV_BITS] ? ONE_Q30 : {1'b0, q_reg[DIV_BITS]};
endmodule

@@ sv/tlik_cordic.sv @@
// Pipelined CORDIC vectoring unit: atan2(y, x) for y >= 0 in Q30 radians.
// Uses tlik_pkg.
module tlik_cordic #(
    parameter int IN_W = 32
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] x,
    input  logic signed [IN_W-1:0] y,
    output logic [tlik_pkg::ZW-1:0] angle
);
    import tlik_pkg::*;

    localparam int W   = IN_W + 26;  // 2^24 scale plus gain and quadrant turn
    localparam int ZSW = ZW + 1;

    logic signed [W-1:0]   x_reg  [CORDIC_STEPS+1];
    logic signed [W-1:0]   y_reg  [CORDIC_STEPS+1];
    logic signed [ZSW-1:0] z_reg  [CORDIC_STEPS+1];
    logic signed [W-1:0]   x_next [CORDIC_STEPS+1];
    logic signed [W-1:0]   y_next [CORDIC_STEPS+1];
    logic signed [ZSW-1:0] z_next [CORDIC_STEPS+1];

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;

    assign xs = W'(x) <<< 24;
    assign ys = W'(y) <<< 24;

    // left half-plane: turn by -90 degrees first
    assign x_next[0] = (xs < 0) ? ys  : xs;
    assign y_next[0] = (xs < 0) ? -xs : ys;
    assign z_next[0] = (xs < 0) ? ZSW'(HALF_PI_Q30) : '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [W-1:0] xsh;
        logic signed [W-1:0] ysh;
        logic                up;
        assign xsh         = x_reg[i] >>> i;
        assign ysh         = y_reg[i] >>> i;
        assign up          = y_reg[i] > 0;
        assign x_next[i+1] = up ? x_reg[i] + ysh : x_reg[i] - ysh;
        assign y_next[i+1] = up ? y_reg[i] - xsh : y_reg[i] + xsh;
        assign z_next[i+1] = up ? z_reg[i] + ZSW'(ATAN_TAB[i]) : z_reg[i] - ZSW'(ATAN_TAB[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS][ZSW-1] ? '0 : z_reg[CORDIC_STEPS][ZW-1:0];
endmodule

@@ sv/tlik_acos.sv @@
// Arccosine of a signed ratio: divide, sqrt(1 - c^2), then CORDIC atan2.
// Uses tlik_pkg, tlik_div, tlik_isqrt, tlik_delay and tlik_cordic.
module tlik_acos #(
    parameter int N_W = 41,
    parameter int D_W = 40
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic                    neg,
    input  logic [N_W-1:0]          n,
    input  logic [D_W-1:0]          d,
    output logic [tlik_pkg::ZW-1:0] angle
);
    import tlik_pkg::*;

    logic [30:0]      q;
    logic             neg_d;
    logic [61:0]      prod;
    logic [QSQ_W-1:0] sq_reg;
    logic [30:0]      q_reg;
    logic             neg_reg;
    logic [QSQ_W-1:0] rem;
    logic [S_LAT-1:0] s;
    logic [30:0]      q_s;
    logic             neg_s;
    logic signed [31:0] c;
    logic signed [31:0] sy;

    tlik_div #(.N_W(N_W), .D_W(D_W)) u_div (
        .clk (clk), .en (en), .n (n), .d (d), .q (q)
    );

    tlik_delay #(.W(1), .DEPTH(DIV_LAT)) u_neg_dly (
        .clk (clk), .en (en), .d (neg), .q (neg_d)
    );

    assign prod = 62'(q) * 62'(q);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= prod[QSQ_W-1:0];
            q_reg   <= q;
            neg_reg <= neg_d;
        end
    end

    assign rem = (QSQ_W'(1) << 60) - sq_reg;

    tlik_isqrt #(.IN_W(QSQ_W)) u_sqrt (
        .clk (clk), .en (en), .value (rem), .root (s)
    );

    tlik_delay #(.W(32), .DEPTH(S_LAT)) u_q_dly (
        .clk (clk), .en (en), .d ({neg_reg, q_reg}), .q ({neg_s, q_s})
    );

    assign c  = neg_s ? -$signed({1'b0, q_s}) : $signed({1'b0, q_s});
    assign sy = $signed({1'b0, s});

    tlik_cordic #(.IN_W(32)) u_cordic (
        .clk (clk), .en (en), .x (c), .y (sy), .angle (angle)
    );
endmodule

@@ tb/sv/two_link_inverse_kinematics_tb.sv @@
// Testbench for two_link_inverse_kinematics: random and directed targets,
// an independent fixed-point IK predictor and an in-order scoreboard class.
// Depends on tlik_pkg and the two_link_inverse_kinematics RTL.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_tb;
    import tlik_pkg::*;

    localparam int LATENCY     = 126;
    localparam int RAND_ITEMS  = 1530;
    localparam longint CYCLE_LIMIT = 400000;

    longint angle_table [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    reg_index_t  cfg_index;
    logic [15:0] cfg_data;
    logic        target_valid;
    logic        target_ready;
    target_t     target;
    logic        result_valid;
    logic        result_ready;
    result_t     result;

    longint unsigned upper_len;
    longint unsigned fore_len;
    longint cycle_count = 0;
    bit     sink_stalls;

    two_link_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .target_valid(target_valid),
        .target_ready(target_ready), .target(target),
        .result_valid(result_valid), .result_ready(result_ready),
        .result(result)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, y >= 0, Q30 radians
    function automatic longint cordic_angle(longint xi, longint yi);
        longint xv, yv, zv, xs, ys, t;
        xv = xi * (64'sd1 << 24);
        yv = yi * (64'sd1 << 24);
        zv = 0;
        if (xv < 0)
        begin
            t = xv;
            xv = yv;
            yv = -t;
            zv = 64'sd1686629713;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0)
            begin
                xv += ys; yv -= xs; zv += angle_table[i];
            end
            else
            begin
                xv -= ys; yv += xs; zv -= angle_table[i];
            end
        end
        return (zv < 0) ? 0 : zv;
    endfunction

    function automatic longint arccos_q30(bit neg, longint unsigned n,
                                         longint unsigned d);
        longint unsigned q, r;
        longint c;
        q = 0;
        if (n >= d)
            q = 64'd1 << 30;
        else
        begin
            r = n;
            for (int i = 0; i < 30; i++)
            begin
                r <<= 1;
                q <<= 1;
                if (r >= d)
                begin
                    r -= d;
                    q |= 1;
                end
            end
        end
        c = neg ? -longint'(q) : longint'(q);
        return cordic_angle(c, longint'(int_sqrt((64'd1 << 60) - q * q)));
    endfunction

    function automatic longint unsigned rad_to_centideg(longint z);
        return (longint'(unsigned'(z)) * 64'd5867088 + (64'd1 << 39)) >> 40;
    endfunction

    function automatic result_t solve_arm(target_t t);
        result_t r;
        longint x, y, a, g;
        longint unsigned ax, ay, p2, sum, dif, big_p, alpha, beta;
        longint za, zb, zg;
        x = longint'(t.target_x);
        y = longint'(t.target_y);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        p2 = ax * ax + ay * ay;
        sum = upper_len + fore_len;
        dif = (upper_len > fore_len) ? upper_len - fore_len : fore_len - upper_len;
        r = '0;
        if (upper_len == 0 || fore_len == 0)
            r.status = ST_ZERO_LEN;
        else if (x == 0 || y == 0)
            r.status = ST_ZERO_COORD;
        else if (p2 > sum * sum)
            r.status = ST_TOO_FAR;
        else if (p2 < dif * dif)
            r.status = ST_TOO_CLOSE;
        else
        begin
            r.status = ST_OK;
            za = cordic_angle(x, longint'(ay));
            big_p = int_sqrt(p2 << 16);
            a = longint'(p2) + longint'(upper_len * upper_len)
                - longint'(fore_len * fore_len);
            zb = arccos_q30(a < 0, longint'(unsigned'((a < 0) ? -a : a)) << 7,
                            upper_len * big_p);
            g = longint'(p2) - longint'(upper_len * upper_len)
                - longint'(fore_len * fore_len);
            zg = arccos_q30(g < 0, (g < 0) ? -g : g, 2 * upper_len * fore_len);
            alpha = rad_to_centideg(za + zb);
            beta = rad_to_centideg(zg);
            if (alpha > 36000) alpha = 36000;
            if (beta > 18000) beta = 18000;
            r.shoulder_angle = alpha[15:0];
            r.elbow_angle = beta[14:0];
        end
        return r;
    endfunction

    class ik_scoreboard;
        result_t pending[$];
        int      mismatches;

        function void note_target(result_t expected_angles);
            pending.push_back(expected_angles);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.shoulder_angle !== want.shoulder_angle
                || got.elbow_angle !== want.elbow_angle
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected shoulder %0d elbow %0d status %0d, ",
                              "got shoulder %0d elbow %0d status %0d"},
                             want.shoulder_angle, want.elbow_angle, want.status,
                             got.shoulder_angle, got.elbow_angle, got.status);
            end
        endfunction
    endclass

    ik_scoreboard board = new;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("two_link_inverse_kinematics_tb failed");
            $finish;
        end
    end

    // result side: check transfers, random stall bursts
    initial
    begin
        int burst;
        result_ready = 1'b0;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                board.check_result(result);
            if (burst > 0)
            begin
                burst--;
                result_ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 16) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == REG_UPPER_ARM)
            upper_len = value;
        else
            fore_len = value;
    endtask

    task automatic set_arms(logic [15:0] l1, logic [15:0] l2);
        write_reg(REG_UPPER_ARM, l1);
        write_reg(REG_FORE_ARM, l2);
        cfg_we <= 1'b0;
    endtask

    // sender holds valid and payload until the transfer
    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                               bit gaps);
        target_t t;
        int gap;
        t.target_x = x;
        t.target_y = y;
        if (gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            target_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target_valid <= 1'b1;
        target <= t;
        do
            @(posedge clk);
        while (!target_ready);
        board.note_target(solve_arm(t));
    endtask

    task automatic drain();
        target_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_len(int mode);
        case (mode)
            0: return 16'($urandom_range(1, 64));
            1: return 16'($urandom_range(256, 4096));
            2: return 16'($urandom_range(1, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    // random target mostly inside the reachable annulus
    task automatic send_random(bit gaps);
        logic signed [15:0] x, y;
        longint unsigned reach, lo, r;
        real ang;
        reach = upper_len + fore_len;
        lo = (upper_len > fore_len) ? upper_len - fore_len : fore_len - upper_len;
        if ($urandom_range(0, 3) == 0 || reach == 0)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            if ($urandom_range(0, 15) == 0) x = 0;
            if ($urandom_range(0, 15) == 0) y = 0;
        end
        else
        begin
            if (reach > 32767) reach = 32767;
            if (lo > reach) lo = reach;
            r = lo + longint'($urandom_range(0, int'(reach - lo)));
            ang = ($urandom_range(0, 62831) / 10000.0);
            x = 16'(longint'($rtoi(r * $cos(ang))));
            y = 16'(longint'($rtoi(r * $sin(ang))));
        end
        send_target(x, y, gaps);
    endtask

    initial
    begin
        int phase_len;
        sink_stalls = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_UPPER_ARM;
        cfg_data = '0;
        target_valid = 1'b0;
        target = '0;
        upper_len = 0;
        fore_len = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero lengths after reset, then extremes
        send_target(16'sh0100, 16'sh0100, 0);
        drain();
        set_arms(16'h0200, 16'h0000);
        send_target(16'sh0100, 16'sh0100, 0);
        drain();
        set_arms(16'h0200, 16'h0180);
        send_target(16'sh0000, 16'sh0100, 0);
        send_target(16'sh0100, 16'sh0000, 0);
        send_target(16'sh7FFF, 16'sh7FFF, 0);
        send_target(-16'sh8000, -16'sh8000, 0);
        send_target(16'sh0001, 16'sh0001, 0);
        send_target(16'sh0200, 16'sh0100, 0);
        send_target(-16'sh0200, 16'sh0100, 0);
        send_target(16'sh0200, -16'sh0100, 0);
        send_target(-16'sh0100, -16'sh0200, 0);
        send_target(16'sh0230, 16'sh0001, 0);
        send_target(16'sh0001, 16'sh0380, 0);
        send_target(-16'sh0380, 16'sh0001, 0);
        drain();
        set_arms(16'hFFFF, 16'hFFFF);
        send_target(16'sh7FFF, -16'sh8000, 0);
        send_target(16'sh0001, -16'sh0001, 0);
        send_target(-16'sh8000, 16'sh7FFF, 0);
        drain();
        set_arms(16'h0001, 16'hFFFF);
        send_target(16'sh7FFF, 16'sh7FFF, 0);
        send_target(16'sh0010, 16'sh0010, 0);
        drain();

        // random phases, each with its own arm lengths
        phase_len = 0;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (phase_len == 0)
            begin
                drain();
                set_arms(rand_len($urandom_range(0, 3)), rand_len($urandom_range(0, 3)));
                phase_len = $urandom_range(50, 200);
            end
            if (i > RAND_ITEMS - 200)
                sink_stalls = 1'b0;
            send_random(i <= RAND_ITEMS - 200);
            phase_len--;
        end
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("two_link_inverse_kinematics_tb passed");
        else
            $display("two_link_inverse_kinematics_tb failed");
        $finish;
    end
endmodule

@@ sim.f @@
sv/tlik_pkg.sv
sv/tlik_delay.sv
sv/tlik_isqrt.sv
sv/tlik_div.sv
sv/tlik_cordic.sv
sv/tlik_acos.sv
sv/two_link_inverse_kinematics.sv
tb/sv/two_link_inverse_kinematics_tb.sv
